### rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg - shared types and constants of the frame rate meter
// Field widths, divider setup values, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

	// field widths
	localparam int STAMP_W = 48;
	localparam int RATE_W  = 28;
	localparam int SUM_W   = 35;
	localparam int WIN_W   = 7;
	localparam int STEP_W  = 6;

	// 1000000 us per second, 8 fraction bits
	localparam logic [RATE_W-1:0] RATE_SCALE = 28'd256000000;

	// divider step counts: the rate numerator is left aligned in the dividend
	localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(RATE_W);
	localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_RATE,
		ST_PUSH,
		ST_DIV_MEAN,
		ST_DONE
	} frm_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // input transfer this cycle
		logic push;      // insert the new rate, start the mean division
		logic cap_mean;  // mean quotient is ready
		logic load_out;  // move statistics into the output register
	} frm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_rate; // frame tick with a nonzero interval
		logic div_done;   // divider finished, quotient valid
		logic out_free;   // output register can take a result
	} frm_stat_t;

endpackage

`default_nettype wire

### rtl/frm_div.sv
// ----------------------------------------------------------------------------
// frm_div - restoring shift-subtract divider
// One quotient bit per cycle, dividend taken from its top bit downward.
// The number of steps is given at start; the quotient sits in the low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_div
	import frm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SUM_W-1:0]   dividend,
	input  wire logic [STAMP_W-1:0] divisor,
	input  wire logic [STEP_W-1:0]  steps,
	output logic                    done,
	output logic [SUM_W-1:0]        quotient
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [STAMP_W-1:0]  rem_q;
	logic [STAMP_W-1:0]  dvs_q;
	logic [SUM_W-1:0]    quo_q;
	logic [STAMP_W:0]    rem_sh;
	logic [STAMP_W:0]    rem_sub;
	logic                ge;
	logic                last;

	// one compare and subtract per step
	always_comb begin
		rem_sh  = {rem_q, quo_q[SUM_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
		last    = cnt_q == STEP_W'(1);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[STAMP_W-1:0] : rem_sh[STAMP_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl - sequencing controller of the frame rate meter
// Takes one input item at a time; a nonzero-interval tick gets the rate
// division, ring update and mean division; the result goes to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ctrl
	import frm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire frm_stat_t stat,
	output logic           in_stall,
	output frm_cmd_t       cmd
);

	frm_state_t state_q;
	frm_state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.needs_rate ? ST_DIV_RATE : ST_DONE;
				end
			end
			ST_DIV_RATE: begin
				if (stat.div_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				state_d = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (stat.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_DIV_RATE: begin
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
			end
			ST_DIV_MEAN: begin
				cmd.cap_mean = stat.div_done;
			end
			ST_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/frm_dpath.sv
// ----------------------------------------------------------------------------
// frm_dpath - datapath of the frame rate meter
// Reference timestamp, rate ring memory with running sum, extremes, the
// shared divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_dpath
	import frm_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire frm_cmd_t           cmd,
	output frm_stat_t               stat,
	input  wire logic               win_len_we,
	input  wire logic [WIN_W-1:0]   win_len,
	input  wire logic               req_type,
	input  wire logic [STAMP_W-1:0] timestamp_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    has_data,
	output logic [RATE_W-1:0]       current_rate,
	output logic [RATE_W-1:0]       average_rate,
	output logic [RATE_W-1:0]       min_rate,
	output logic [RATE_W-1:0]       max_rate
);

	localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW      = (AW + 1 > WIN_W + 1) ? AW + 1 : WIN_W + 1;
	localparam int WIN_RST = (60 > WINDOW_MAX) ? WINDOW_MAX : 60;

	logic [STAMP_W-1:0] last_stamp_q;
	logic [WIN_W-1:0]   win_q;
	logic [AW-1:0]      slot_q;
	logic [WIN_W-1:0]   fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RATE_W-1:0]  newest_q;
	logic [RATE_W-1:0]  mean_q;
	logic [RATE_W-1:0]  low_q;
	logic [RATE_W-1:0]  high_q;
	logic               seen_q;
	logic [RATE_W-1:0]  ring [WINDOW_MAX];
	logic [RATE_W-1:0]  old_rate_q;

	logic [STAMP_W-1:0] interval;
	logic [WIN_W-1:0]   win_new;
	logic               full;
	logic [WIN_W-1:0]   fill_d;
	logic [SUM_W-1:0]   sum_d;
	logic [SW-1:0]      slot_inc;
	logic [RATE_W-1:0]  rate;

	logic               div_start;
	logic [SUM_W-1:0]   div_dvd;
	logic [STAMP_W-1:0] div_dvs;
	logic [STEP_W-1:0]  div_steps;
	logic               div_done;
	logic [SUM_W-1:0]   div_quo;

	logic               out_valid_q;
	logic               out_has_q;
	logic [RATE_W-1:0]  out_cur_q;
	logic [RATE_W-1:0]  out_avg_q;
	logic [RATE_W-1:0]  out_min_q;
	logic [RATE_W-1:0]  out_max_q;

	// interval modulo 2^48 and clamped window size
	always_comb begin
		interval = timestamp_us - last_stamp_q;
		win_new  = win_len;
		if (win_new == '0) begin
			win_new = WIN_W'(1);
		end
		if (32'(win_new) > WINDOW_MAX) begin
			win_new = WIN_W'(WINDOW_MAX);
		end
	end

	// ring insertion arithmetic
	always_comb begin
		rate     = div_quo[RATE_W-1:0];
		full     = fill_q >= win_q;
		fill_d   = full ? fill_q : fill_q + WIN_W'(1);
		sum_d    = sum_q - (full ? SUM_W'(old_rate_q) : '0) + SUM_W'(rate);
		slot_inc = SW'(slot_q) + SW'(1);
	end

	// divider operands: rate on input transfer, mean on insertion
	always_comb begin
		div_start = (cmd.take && stat.needs_rate) || cmd.push;
		if (cmd.push) begin
			div_dvd   = sum_d;
			div_dvs   = STAMP_W'(fill_d);
			div_steps = MEAN_STEPS;
		end else begin
			div_dvd   = {RATE_SCALE, (SUM_W - RATE_W)'(0)};
			div_dvs   = interval;
			div_steps = RATE_STEPS;
		end
	end

	frm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	// status to the controller
	always_comb begin
		stat.needs_rate = !req_type && (interval != '0);
		stat.div_done   = div_done;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// rate ring memory, read at the write slot
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring[slot_q] <= rate;
		end
		old_rate_q <= ring[slot_q];
	end

	// reference, ring control and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			win_q        <= WIN_W'(WIN_RST);
			slot_q       <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			newest_q     <= '0;
			mean_q       <= '0;
			low_q        <= '0;
			high_q       <= '0;
			seen_q       <= 1'b0;
		end else begin
			if (win_len_we) begin
				win_q  <= win_new;
				slot_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.take) begin
				last_stamp_q <= timestamp_us;
				if (req_type) begin
					slot_q   <= '0;
					fill_q   <= '0;
					sum_q    <= '0;
					newest_q <= '0;
					mean_q   <= '0;
					low_q    <= '0;
					high_q   <= '0;
					seen_q   <= 1'b0;
				end
			end
			if (cmd.push) begin
				fill_q   <= fill_d;
				sum_q    <= sum_d;
				slot_q   <= (slot_inc >= SW'(win_q)) ? '0 : slot_inc[AW-1:0];
				newest_q <= rate;
				seen_q   <= 1'b1;
				if (!seen_q || rate < low_q) begin
					low_q <= rate;
				end
				if (!seen_q || rate > high_q) begin
					high_q <= rate;
				end
			end
			if (cmd.cap_mean) begin
				mean_q <= div_quo[RATE_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_has_q <= seen_q;
			out_cur_q <= newest_q;
			out_avg_q <= mean_q;
			out_min_q <= low_q;
			out_max_q <= high_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign has_data     = out_has_q;
	assign current_rate = out_cur_q;
	assign average_rate = out_avg_q;
	assign min_rate     = out_min_q;
	assign max_rate     = out_max_q;

endmodule

`default_nettype wire

### rtl/frame_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_unit - frame rate meter with moving average and extremes
// A frame tick turns a nonzero microsecond interval since the previous
// item into a rate in frames per second with 8 fraction bits, averages it
// over a ring of recent rates and tracks the lowest and highest rate.
// ----------------------------------------------------------------------------
// One result comes out for every input item. A frame tick with a nonzero
// interval goes through the rate division in the shared shift-subtract
// divider, the insertion of the rate into the ring, the division for the
// window mean and the handoff to the output register. A restart item or
// a tick that repeats the previous timestamp skips the divisions. Items are
// handled one at a time; the next item is taken as soon as the result is
// placed in the output register, even while that result waits to be taken.
// Writing the window length clears the ring (values 0 and above WINDOW_MAX
// are clamped) and is to be done only while the meter is idle. No clearing
// pass follows reset.
`default_nettype none

module frame_rate_meter_unit
	import frm_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               win_len_we,
	input  wire logic [WIN_W-1:0]   win_len,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [STAMP_W-1:0] timestamp_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    has_data,
	output logic [RATE_W-1:0]       current_rate,
	output logic [RATE_W-1:0]       average_rate,
	output logic [RATE_W-1:0]       min_rate,
	output logic [RATE_W-1:0]       max_rate
);

	frm_cmd_t  cmd;
	frm_stat_t stat;

	// sequencing
	frm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// arithmetic and storage
	frm_dpath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.win_len_we   (win_len_we),
		.win_len      (win_len),
		.req_type     (req_type),
		.timestamp_us (timestamp_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.has_data     (has_data),
		.current_rate (current_rate),
		.average_rate (average_rate),
		.min_rate     (min_rate),
		.max_rate     (max_rate)
	);

endmodule

`default_nettype wire
